// File: rtl/core/ipv4pf_pkg.sv
// Shared types and constants for the IPv4 port and source filter.
// Used by the front parser, the command queue, the back engine and the top level.
`default_nettype none

package ipv4pf_pkg;

  // item actions, also used as queue operation codes
  localparam logic [1:0] ACT_FRAME   = 2'd0;
  localparam logic [1:0] ACT_PORT_WR = 2'd1;
  localparam logic [1:0] ACT_BL_WR   = 2'd2;

  // verdict causes
  localparam logic [2:0] CAUSE_NON_IP = 3'd0;
  localparam logic [2:0] CAUSE_IPV6   = 3'd1;
  localparam logic [2:0] CAUSE_CLEAN  = 3'd2;
  localparam logic [2:0] CAUSE_TRUNC  = 3'd3;
  localparam logic [2:0] CAUSE_PORT   = 3'd4;
  localparam logic [2:0] CAUSE_SOURCE = 3'd5;

  // configuration registers
  localparam int         CFG_IDX_W    = 1;
  localparam logic [0:0] CFG_EXEMPT_A = 1'b0;
  localparam logic [0:0] CFG_EXEMPT_B = 1'b1;
  localparam logic [15:0] EXEMPT_A_RESET = 16'd22;
  localparam logic [15:0] EXEMPT_B_RESET = 16'd9998;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] table_index;
    logic [31:0] source_address;
    logic [31:0] entry_value;
  } item_t;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  cause;
    logic [63:0] allowed_count;
    logic [63:0] dropped_count;
  } result_t;

  // one queued command: a table write or a classified frame
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  cause;  // final cause when no lookup is needed
    logic        check;  // full IPv4 header: count, and run lookups unless truncated
    logic        trunc;  // layer-4 header cut short
    logic        flag;   // write value, or port within the table
    logic [15:0] index;  // table index or destination port
    logic [31:0] addr;   // blacklist address or captured source
  } qentry_t;

endpackage

`default_nettype wire

// File: rtl/core/ipv4_port_and_source_filter_unit.sv
// IPv4 port and source filter: one frame byte or one table write per transfer,
// one verdict per frame. The item channel takes a transfer every cycle while
// the 4-entry command queue has room; bytes that are not a frame's last byte
// never reach the queue. The back engine, with one read port per table,
// applies a table write as it takes it; a non-IPv4, IPv6, short or truncated
// frame goes straight to its verdict, and a full IPv4 frame gets a port lookup
// and then, unless the port drops it, a blacklist scan of one slot per cycle
// that stops at a hit. The result sits in its own register, so the engine moves
// on while a verdict waits. After reset the tables are cleared one address at a
// time with the item channel stalled; configuration writes are taken at any
// time.
`default_nettype none

module ipv4_port_and_source_filter_unit #(
  parameter int PORT_ENTRIES  = 65536,
  parameter int BLOCK_ENTRIES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire ipv4pf_pkg::item_t                 item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output ipv4pf_pkg::result_t                    result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ipv4pf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  logic                accept, push, pop, q_full, q_empty, clearing;
  ipv4pf_pkg::qentry_t entry, head;

  assign cfg_ready  = 1'b1;
  assign item_stall = q_full || clearing;
  assign accept     = item_valid && !item_stall;

  ipv4pf_front #(
    .PORT_ENTRIES (PORT_ENTRIES),
    .BLOCK_ENTRIES(BLOCK_ENTRIES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .accept(accept),
    .push  (push),
    .entry (entry)
  );

  ipv4pf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(entry),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ipv4pf_back #(
    .PORT_ENTRIES (PORT_ENTRIES),
    .BLOCK_ENTRIES(BLOCK_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .clearing    (clearing),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire

// File: rtl/core/ipv4pf_front.sv
// Front end: parses frame bytes, classifies each frame at its last byte and
// turns table writes into queue commands. Depends on ipv4pf_pkg.
`default_nettype none

module ipv4pf_front #(
  parameter int PORT_ENTRIES  = 65536,
  parameter int BLOCK_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ipv4pf_pkg::item_t  item,
  input  wire logic               accept,
  output logic                    push,
  output ipv4pf_pkg::qentry_t     entry
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] ether_type, ether_type_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [31:0] captured_source, captured_source_next;
  logic [15:0] captured_port, captured_port_next;

  logic [15:0] len;
  logic [6:0]  l4_cur, l4_n, l4_end;
  logic [4:0]  need;
  logic        has_port;
  logic [15:0] port;
  logic        is_frame;
  logic [7:0]  b;

  assign b        = item.frame_byte;
  assign is_frame = accept && (item.action == ipv4pf_pkg::ACT_FRAME);

  always_comb begin
    l4_cur               = 7'd14 + {1'b0, header_words, 2'b00};
    ether_type_next      = ether_type;
    header_words_next    = header_words;
    ip_protocol_next     = ip_protocol;
    captured_source_next = captured_source;
    captured_port_next   = captured_port;
    len                  = byte_position;
    if (byte_position != 16'hFFFF) begin
      len = byte_position + 16'd1;
      if (byte_position == 16'd12) ether_type_next[15:8] = b;
      if (byte_position == 16'd13) ether_type_next[7:0] = b;
      if (byte_position == 16'd14) header_words_next = b[3:0];
      if (byte_position == 16'd23) ip_protocol_next = b;
      if (byte_position >= 16'd26 && byte_position <= 16'd29)
        captured_source_next = {captured_source[23:0], b};
      if (byte_position > 16'd14) begin
        if (byte_position == {9'd0, l4_cur} + 16'd2) captured_port_next[15:8] = b;
        if (byte_position == {9'd0, l4_cur} + 16'd3) captured_port_next[7:0] = b;
      end
    end
  end

  // classification on the values that include the last byte
  always_comb begin
    l4_n     = 7'd14 + {1'b0, header_words_next, 2'b00};
    need     = 5'd0;
    has_port = 1'b0;
    case (ip_protocol_next)
      ipv4pf_pkg::PROTO_TCP:  begin need = 5'd20; has_port = 1'b1; end
      ipv4pf_pkg::PROTO_UDP:  begin need = 5'd8;  has_port = 1'b1; end
      ipv4pf_pkg::PROTO_ICMP: need = 5'd8;
      default:                need = 5'd0;
    endcase
    l4_end = l4_n + {2'b00, need};
    port   = has_port ? captured_port_next : 16'd0;
  end

  always_comb begin
    entry       = '0;
    entry.op    = item.action;
    entry.index = item.table_index;
    entry.addr  = item.source_address;
    push        = 1'b0;
    case (item.action)
      ipv4pf_pkg::ACT_FRAME: begin
        push        = is_frame && item.frame_last;
        entry.index = port;
        entry.addr  = captured_source_next;
        entry.flag  = {1'b0, port} < 17'(PORT_ENTRIES);
        entry.trunc = (need != 5'd0) && (len < {9'd0, l4_end});
        if (len < 16'd14)
          entry.cause = ipv4pf_pkg::CAUSE_TRUNC;
        else if (ether_type_next != ipv4pf_pkg::ETH_IPV4 &&
                 ether_type_next != ipv4pf_pkg::ETH_IPV6)
          entry.cause = ipv4pf_pkg::CAUSE_NON_IP;
        else if (ether_type_next == ipv4pf_pkg::ETH_IPV6)
          entry.cause = (len < 16'd54) ? ipv4pf_pkg::CAUSE_TRUNC : ipv4pf_pkg::CAUSE_IPV6;
        else if (len < 16'd34)
          entry.cause = ipv4pf_pkg::CAUSE_TRUNC;
        else
          entry.check = 1'b1;
      end
      ipv4pf_pkg::ACT_PORT_WR: begin
        push       = accept && ({1'b0, item.table_index} < 17'(PORT_ENTRIES));
        entry.flag = item.entry_value == 32'd1;
      end
      ipv4pf_pkg::ACT_BL_WR: begin
        push       = accept && ({1'b0, item.table_index} < 17'(BLOCK_ENTRIES));
        entry.flag = item.entry_value != 32'd0;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (is_frame && item.frame_last)) begin
      byte_position   <= '0;
      ether_type      <= '0;
      header_words    <= '0;
      ip_protocol     <= '0;
      captured_source <= '0;
      captured_port   <= '0;
    end else if (is_frame) begin
      byte_position   <= byte_position_next;
      ether_type      <= ether_type_next;
      header_words    <= header_words_next;
      ip_protocol     <= ip_protocol_next;
      captured_source <= captured_source_next;
      captured_port   <= captured_port_next;
    end
  end

  assign byte_position_next = len;

endmodule

`default_nettype wire

// File: rtl/core/ipv4pf_queue.sv
// Short command queue between the front parser and the back engine.
// Depends on ipv4pf_pkg.
`default_nettype none

module ipv4pf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ipv4pf_pkg::qentry_t  push_data,
  input  wire logic                 pop,
  output ipv4pf_pkg::qentry_t       head,
  output logic                      full,
  output logic                      empty
);

  ipv4pf_pkg::qentry_t slots [ipv4pf_pkg::QUEUE_DEPTH];
  logic [ipv4pf_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [ipv4pf_pkg::QUEUE_AW:0]   count;

  assign full  = count == (ipv4pf_pkg::QUEUE_AW+1)'(ipv4pf_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (ipv4pf_pkg::QUEUE_AW+1)'(ipv4pf_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/core/ipv4pf_back.sv
// Back engine: applies table writes, looks up the port table, scans the
// blacklist, keeps the counters and registers the result. Depends on ipv4pf_pkg.
`default_nettype none

module ipv4pf_back #(
  parameter int PORT_ENTRIES  = 65536,
  parameter int BLOCK_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ipv4pf_pkg::qentry_t                 head,
  input  wire logic                                empty,
  output logic                                     pop,
  output logic                                     clearing,
  input  wire logic                                cfg_valid,
  input  wire logic [ipv4pf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                         cfg_data,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output ipv4pf_pkg::result_t                      result
);

  localparam int PORT_AW    = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
  localparam int BL_AW      = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int PORT_DEPTH = 2 ** PORT_AW;
  localparam int BL_DEPTH   = 2 ** BL_AW;
  localparam int CLR_N      = (PORT_DEPTH > BL_DEPTH) ? PORT_DEPTH : BL_DEPTH;
  localparam int CLR_AW     = $clog2(CLR_N);

  typedef struct packed {
    logic        active;
    logic [31:0] addr;
  } bl_entry_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_RUN   = 5'b00010,
    S_PORT  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic      port_mem [PORT_DEPTH];
  bl_entry_t bl_mem [BL_DEPTH];

  logic               port_we, port_wdata, port_rd;
  logic [PORT_AW-1:0] port_waddr, port_raddr;
  logic               bl_we;
  bl_entry_t          bl_wdata, bl_rd;
  logic [BL_AW-1:0]   bl_waddr, bl_raddr;

  logic [CLR_AW-1:0] clr_cnt, clr_cnt_next;
  logic [BL_AW-1:0]  scan_idx, scan_idx_next;
  logic [2:0]        cause_q, cause_q_next;
  logic [63:0]       allowed, allowed_next, dropped, dropped_next;
  logic [15:0]       port_q, port_q_next;
  logic              port_ok_q, port_ok_q_next;
  logic [31:0]       src_q, src_q_next;
  logic [15:0]       exempt_a, exempt_b;
  logic              scan_hit, load;

  assign clearing = state == S_CLEAR;
  assign scan_hit = bl_rd.active && (bl_rd.addr == src_q);
  assign load     = (state == S_EMIT) && (!result_valid || !result_stall);

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    scan_idx_next  = scan_idx;
    cause_q_next   = cause_q;
    allowed_next   = allowed;
    dropped_next   = dropped;
    port_q_next    = port_q;
    port_ok_q_next = port_ok_q;
    src_q_next     = src_q;
    pop            = 1'b0;
    port_we        = 1'b0;
    port_waddr     = head.index[PORT_AW-1:0];
    port_wdata     = head.flag;
    port_raddr     = head.index[PORT_AW-1:0];
    bl_we          = 1'b0;
    bl_waddr       = head.index[BL_AW-1:0];
    bl_wdata       = {head.flag, head.addr};
    bl_raddr       = (state == S_PORT) ? '0 : scan_idx + 1'b1;

    unique case (state)
      S_CLEAR: begin
        port_we    = 1'b1;
        port_waddr = clr_cnt[PORT_AW-1:0];
        port_wdata = 1'b0;
        bl_we      = 1'b1;
        bl_waddr   = clr_cnt[BL_AW-1:0];
        bl_wdata   = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_AW'(CLR_N - 1)) state_next = S_RUN;
      end
      S_RUN: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.op)
            ipv4pf_pkg::ACT_PORT_WR: port_we = 1'b1;
            ipv4pf_pkg::ACT_BL_WR:   bl_we = 1'b1;
            ipv4pf_pkg::ACT_FRAME: begin
              if (!head.check) begin
                cause_q_next = head.cause;
                state_next   = S_EMIT;
              end else begin
                allowed_next = allowed + 64'd1;
                if (head.trunc) begin
                  cause_q_next = ipv4pf_pkg::CAUSE_TRUNC;
                  state_next   = S_EMIT;
                end else begin
                  port_q_next    = head.index;
                  port_ok_q_next = head.flag;
                  src_q_next     = head.addr;
                  state_next     = S_PORT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PORT: begin
        // port_rd holds the table bit for port_q
        if (port_ok_q && port_rd && port_q != exempt_a && port_q != exempt_b) begin
          dropped_next = dropped + 64'd1;
          cause_q_next = ipv4pf_pkg::CAUSE_PORT;
          state_next   = S_EMIT;
        end else begin
          scan_idx_next = '0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          dropped_next = dropped + 64'd1;
          cause_q_next = ipv4pf_pkg::CAUSE_SOURCE;
          state_next   = S_EMIT;
        end else if (scan_idx == BL_AW'(BLOCK_ENTRIES - 1)) begin
          cause_q_next = ipv4pf_pkg::CAUSE_CLEAN;
          state_next   = S_EMIT;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_EMIT: begin
        if (load) state_next = S_RUN;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (port_we) port_mem[port_waddr] <= port_wdata;
    port_rd <= port_mem[port_raddr];
    if (bl_we) bl_mem[bl_waddr] <= bl_wdata;
    bl_rd <= bl_mem[bl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      allowed      <= '0;
      dropped      <= '0;
      exempt_a     <= ipv4pf_pkg::EXEMPT_A_RESET;
      exempt_b     <= ipv4pf_pkg::EXEMPT_B_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      allowed      <= allowed_next;
      dropped      <= dropped_next;
      result_valid <= load || (result_valid && result_stall);
      if (cfg_valid && cfg_index == ipv4pf_pkg::CFG_EXEMPT_A) exempt_a <= cfg_data;
      if (cfg_valid && cfg_index == ipv4pf_pkg::CFG_EXEMPT_B) exempt_b <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    cause_q   <= cause_q_next;
    port_q    <= port_q_next;
    port_ok_q <= port_ok_q_next;
    src_q     <= src_q_next;
    if (load) begin
      result.verdict       <= cause_q >= ipv4pf_pkg::CAUSE_TRUNC;
      result.cause         <= cause_q;
      result.allowed_count <= allowed;
      result.dropped_count <= dropped;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("command taken during clearing pass");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_hit && scan_idx == BL_AW'(BLOCK_ENTRIES - 1))
    |=> (state == S_EMIT && cause_q == ipv4pf_pkg::CAUSE_CLEAN))
    else $error("blacklist scan did not finish clean");
  a_drop_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && dropped != $past(dropped))
    |-> (cause_q == ipv4pf_pkg::CAUSE_PORT || cause_q == ipv4pf_pkg::CAUSE_SOURCE))
    else $error("drop counter moved without a drop cause");

endmodule

`default_nettype wire

// File: bench/ipv4pf_checker.sv
// Checker for the IPv4 port and source filter: watches the item, result and
// configuration channels, predicts each verdict and compares it.
// Depends on ipv4pf_pkg for the payload types and codes.
module ipv4pf_checker
  import ipv4pf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int PORTS = 65536;
  localparam int SLOTS = 64;

  bit          port_marked [PORTS];
  logic [31:0] slot_addr [SLOTS];
  bit          slot_on [SLOTS];
  logic [15:0] exempt_a, exempt_b;
  logic [15:0] pos, etype, dport;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [63:0] allowed_total, dropped_total;
  result_t     verdict_q[$];

  assign pending = verdict_q.size();

  function automatic logic [2:0] classify(input int len);
    int l4, need;
    logic [15:0] p;
    need = 0;
    p = '0;
    if (len < 14) return CAUSE_TRUNC;
    if (etype != ETH_IPV4 && etype != ETH_IPV6) return CAUSE_NON_IP;
    if (etype == ETH_IPV6) return (len < 54) ? CAUSE_TRUNC : CAUSE_IPV6;
    if (len < 34) return CAUSE_TRUNC;
    allowed_total += 1;
    l4 = 14 + 4 * ihl;
    if (proto == PROTO_TCP) begin
      need = 20;
      p = dport;
    end else if (proto == PROTO_UDP) begin
      need = 8;
      p = dport;
    end else if (proto == PROTO_ICMP) begin
      need = 8;
    end
    if (need != 0 && len < l4 + need) return CAUSE_TRUNC;
    if (port_marked[p] && p != exempt_a && p != exempt_b) begin
      dropped_total += 1;
      return CAUSE_PORT;
    end
    for (int i = 0; i < SLOTS; i++)
      if (slot_on[i] && slot_addr[i] == src) begin
        dropped_total += 1;
        return CAUSE_SOURCE;
      end
    return CAUSE_CLEAN;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int l4;
    result_t r;
    if (pos != 16'hFFFF) begin
      l4 = 14 + 4 * ihl;
      if (pos == 12) etype[15:8] = b;
      if (pos == 13) etype[7:0] = b;
      if (pos == 14) ihl = b[3:0];
      if (pos == 23) proto = b;
      if (pos >= 26 && pos <= 29) src = {src[23:0], b};
      if (pos > 14 && pos == l4 + 2) dport[15:8] = b;
      if (pos > 14 && pos == l4 + 3) dport[7:0] = b;
      pos++;
    end
    if (last) begin
      r.cause = classify(int'(pos));
      r.verdict = (r.cause >= CAUSE_TRUNC);
      r.allowed_count = allowed_total;
      r.dropped_count = dropped_total;
      verdict_q.push_back(r);
      {pos, etype, ihl, proto, src, dport} = '0;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      foreach (port_marked[i]) port_marked[i] = 0;
      foreach (slot_on[i]) begin
        slot_on[i] = 0;
        slot_addr[i] = '0;
      end
      exempt_a = EXEMPT_A_RESET;
      exempt_b = EXEMPT_B_RESET;
      {pos, etype, ihl, proto, src, dport} = '0;
      allowed_total = 0;
      dropped_total = 0;
      verdict_q.delete();
      errors = 0;
    end else begin
      // result first: a verdict cannot leave in the cycle its last byte enters
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected verdict transfer");
          errors++;
        end else begin
          e = verdict_q.pop_front();
          if (result.verdict !== e.verdict) begin
            $error("verdict: expected %0d, got %0d", e.verdict, result.verdict);
            errors++;
          end
          if (result.cause !== e.cause) begin
            $error("cause: expected %0d, got %0d", e.cause, result.cause);
            errors++;
          end
          if (result.allowed_count !== e.allowed_count) begin
            $error("allowed_count: expected %0d, got %0d", e.allowed_count,
                   result.allowed_count);
            errors++;
          end
          if (result.dropped_count !== e.dropped_count) begin
            $error("dropped_count: expected %0d, got %0d", e.dropped_count,
                   result.dropped_count);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        case (item.action)
          ACT_FRAME:   take_byte(item.frame_byte, item.frame_last);
          ACT_PORT_WR: port_marked[item.table_index] = (item.entry_value == 1);
          ACT_BL_WR:
            if (item.table_index < SLOTS) begin
              slot_addr[item.table_index] = item.source_address;
              slot_on[item.table_index] = (item.entry_value != 0);
            end
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_EXEMPT_A) exempt_a = cfg_data;
        else exempt_b = cfg_data;
      end
    end
  end

endmodule

// File: bench/tb_ipv4_port_and_source_filter_unit.sv
// Testbench top for ipv4_port_and_source_filter_unit: drives frames, table
// writes and register writes with random idling and gives the verdict.
// Depends on ipv4pf_pkg, the block and ipv4pf_checker.
module tb_ipv4_port_and_source_filter_unit;
  import ipv4pf_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  bit          quiet;
  int          stall_left;
  int          sent;
  logic [15:0] port_pool[7];
  logic [31:0] addr_pool[6];

  ipv4_port_and_source_filter_unit u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ipv4pf_checker u_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      result_stall <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      result_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic send(input item_t x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= x;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  // fields other than the action's own carry random bits, which must be ignored
  function automatic item_t noise_item(input logic [1:0] act);
    item_t x;
    x = $bits(item_t)'({$urandom, $urandom, $urandom});
    x.action = act;
    return x;
  endfunction

  task automatic send_frame(input logic [15:0] etype, input int len, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [31:0] src,
                            input logic [15:0] port);
    item_t x;
    int l4;
    l4 = 14 + 4 * ihl;
    for (int i = 0; i < len; i++) begin
      x = noise_item(ACT_FRAME);
      x.frame_last = (i == len - 1);
      if (i == 12) x.frame_byte = etype[15:8];
      if (i == 13) x.frame_byte = etype[7:0];
      if (i == 14) x.frame_byte[3:0] = ihl;
      if (i == 23) x.frame_byte = proto;
      if (i >= 26 && i <= 29) x.frame_byte = src[8 * (29 - i) +: 8];
      if (i > 14 && i == l4 + 2) x.frame_byte = port[15:8];
      if (i > 14 && i == l4 + 3) x.frame_byte = port[7:0];
      send(x);
    end
  endtask

  task automatic write_port(input logic [15:0] p, input logic [31:0] v);
    item_t x;
    x = noise_item(ACT_PORT_WR);
    x.table_index = p;
    x.entry_value = v;
    send(x);
  endtask

  task automatic write_slot(input logic [15:0] s, input logic [31:0] a, input logic [31:0] v);
    item_t x;
    x = noise_item(ACT_BL_WR);
    x.table_index = s;
    x.source_address = a;
    x.entry_value = v;
    send(x);
  endtask

  // cfg_valid stays high so writes can follow back to back; caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // engine may still be busy with table writes after the last verdict
  task automatic drain();
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_ipv4();
    logic [3:0]  ihl;
    logic [7:0]  proto;
    int          need, len, r;
    ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    r = $urandom_range(0, 9);
    proto = (r < 4) ? PROTO_TCP : (r < 7) ? PROTO_UDP : (r < 8) ? PROTO_ICMP : 8'($urandom);
    need = (proto == PROTO_TCP) ? 20 : 8;
    len = 14 + 4 * ihl + need;
    if (len < 34) len = 34;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len + $urandom_range(0, 10);
    send_frame(ETH_IPV4, len, ihl, proto,
               ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 5)],
               ($urandom_range(0, 5) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 6)]);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) random_ipv4();
    else if (r < 72) send_frame(ETH_IPV6, $urandom_range(30, 70), 4'($urandom), 8'($urandom),
                                $urandom, 16'($urandom));
    else if (r < 78) send_frame(16'($urandom), $urandom_range(1, 40), 4'($urandom),
                                8'($urandom), $urandom, 16'($urandom));
    else if (r < 88) write_port(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                : port_pool[$urandom_range(0, 6)],
                                ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 1)));
    else if (r < 97) write_slot(($urandom_range(0, 7) == 0) ? 16'($urandom)
                                : 16'($urandom_range(0, 63)), addr_pool[$urandom_range(0, 5)],
                                ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
    else send(noise_item(2'd3));
  endtask

  initial begin
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    result_stall <= 1'b0;
    stall_left = 0;
    quiet = 0;
    sent = 0;
    port_pool = '{16'd22, 16'd9998, 16'd80, 16'd443, 16'd0, 16'd65535, 16'($urandom)};
    addr_pool = '{32'd0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101, $urandom, $urandom};
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_EXEMPT_A, 16'd0);
    write_reg(CFG_EXEMPT_B, 16'hFFFF);
    cfg_valid <= 1'b0;

    // directed corners
    quiet = 1;
    send_frame(16'h1234, 5, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    send_frame(ETH_IPV4, 13, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    send_frame(16'h1234, 14, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    send_frame(ETH_IPV6, 53, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    send_frame(ETH_IPV6, 54, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    send_frame(ETH_IPV4, 33, 4'd5, PROTO_TCP, 32'd0, 16'd0);
    write_port(16'd80, 32'd1);
    write_port(16'd0, 32'd1);
    write_port(16'hFFFF, 32'd2);
    write_slot(16'd63, 32'h0A00_0001, 32'hFFFF_FFFF);
    write_slot(16'd5, 32'hC0A8_0101, 32'd0);
    write_slot(16'd64, 32'h0A00_0002, 32'd1);
    send(noise_item(2'd3));
    send_frame(ETH_IPV4, 53, 4'd5, PROTO_TCP, 32'h1, 16'd80);
    send_frame(ETH_IPV4, 54, 4'd5, PROTO_TCP, 32'h1, 16'd80);
    send_frame(ETH_IPV4, 40, 4'd5, PROTO_UDP, 32'h1, 16'd0);
    send_frame(ETH_IPV4, 42, 4'd5, PROTO_ICMP, 32'h1, 16'd0);
    send_frame(ETH_IPV4, 34, 4'd5, 8'hFF, 32'h1, 16'd0);
    send_frame(ETH_IPV4, 40, 4'd0, PROTO_UDP, 32'h0A00_0001, 16'd443);
    send_frame(ETH_IPV4, 94, 4'd15, PROTO_TCP, 32'h0A00_0001, 16'd9998);
    send_frame(ETH_IPV4, 60, 4'd5, PROTO_TCP, 32'hC0A8_0101, 16'd443);
    send_frame(ETH_IPV4, 65540, 4'd5, PROTO_UDP, 32'h0A00_0002, 16'd22);
    quiet = 0;
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_EXEMPT_A, 16'd80);
          write_reg(CFG_EXEMPT_B, 16'd0);
        end
        1: begin
          write_reg(CFG_EXEMPT_A, 16'($urandom));
          write_reg(CFG_EXEMPT_B, 16'($urandom));
        end
        default: begin
          write_reg(CFG_EXEMPT_A, EXEMPT_A_RESET);
          write_reg(CFG_EXEMPT_B, EXEMPT_B_RESET);
        end
      endcase
      cfg_valid <= 1'b0;
      sent = 0;
      while (sent < 650) begin
        quiet = ($urandom_range(0, 7) == 0);
        random_item();
      end
      quiet = 0;
      drain();
    end

    if (errors == 0)
      $display("tb_ipv4_port_and_source_filter_unit: done, clean");
    else
      $display("tb_ipv4_port_and_source_filter_unit: done, errors");
    $finish;
  end

  initial begin
    #24_000_000;
    $display("tb_ipv4_port_and_source_filter_unit: done, errors");
    $finish;
  end

endmodule
